// File: design/frfe_pkg.sv
// Shared types and constants for the frame rotate/flip engine.
// Used by frfe_ctrl, frfe_datapath and frame_rotate_flip_engine; depends on nothing.
package frfe_pkg;

    localparam int PIXEL_W        = 24;
    localparam int DIM_W          = 9;
    localparam int MODE_W         = 3;
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam logic [MODE_W-1:0] MODE_ROT_CW   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ROT_CCW  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROT_180  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLIP_V   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MIRROR_H = 3'd4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic accept;
        logic exec_write;
        logic exec_read;
        logic calc;
        logic mem_read;
        logic load_out;
    } frfe_cmd_t;

    typedef struct packed {
        logic is_read;
    } frfe_status_t;

endpackage

// File: design/frame_rotate_flip_engine.sv
// Top level of the frame rotate/flip engine: configuration registers and module wiring.
// Depends on frfe_pkg, frfe_ctrl and frfe_datapath.
//
// Usage: the slave stream carries one transaction per item. s_tuser selects the kind:
// a write stores s_tdata as the next source pixel in raster order into the frame store
// (the position wraps after the last pixel of the frame); a read produces one master
// transaction with the next pixel of the transformed frame, m_tlast marking its last pixel.
// The APB port sets width, height and mode and may be written only while the engine is idle.
// Timing: the controller handles one transaction at a time. A write is captured and then
// stored into the frame store before the controller returns to idle. A read passes 5 steps
// (capture, counter and operand stage, address multiply-add, registered frame store read,
// output load); after the output load the controller returns to idle and accepts the next item,
// also while the pixel still waits in the output register.
// If the receiver stalls, the following read holds in its final step until the output
// register frees up. Reset clears the write position, the read row and column and the
// output valid flag and restores the default configuration; frame store contents are
// undefined until written, with no clearing pass.
module frame_rotate_flip_engine #(
    parameter int MAX_WIDTH  = frfe_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = frfe_pkg::MAX_HEIGHT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [frfe_pkg::PIXEL_W-1:0] s_tdata,  // pixel_in
    input  logic                         s_tuser,  // opcode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [frfe_pkg::PIXEL_W-1:0] m_tdata,  // pixel_out
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import frfe_pkg::*;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              cfg_write;
    logic [1:0]        reg_index;
    frfe_cmd_t         cmd;
    frfe_status_t      status;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_index)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_MODE:   prdata = 32'(mode_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(256);
            height_reg <= DIM_W'(256);
            mode_reg   <= MODE_ROT_CW;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_MODE:   mode_reg   <= pwdata[MODE_W-1:0];
                default:    ;
            endcase
        end
    end

    frfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    frfe_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .image_width    (width_reg),
        .image_height   (height_reg),
        .transform_mode (mode_reg),
        .opcode         (s_tuser),
        .pixel_in       (s_tdata),
        .cmd            (cmd),
        .status         (status),
        .pixel_out      (m_tdata),
        .end_of_frame   (m_tlast)
    );

endmodule

// File: design/frfe_ctrl.sv
// Controller state machine of the frame rotate/flip engine.
// Depends on frfe_pkg; drives the command struct of frfe_datapath.
module frfe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  frfe_pkg::frfe_status_t status,
    output frfe_pkg::frfe_cmd_t    cmd
);
    import frfe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CALC,
        S_READ,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   load_out;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign load_out = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = (state_reg == S_IDLE) && s_tvalid;
        cmd.exec_write = (state_reg == S_EXEC) && (status.is_read == OP_WRITE);
        cmd.exec_read  = (state_reg == S_EXEC) && (status.is_read == OP_READ);
        cmd.calc       = (state_reg == S_CALC);
        cmd.mem_read   = (state_reg == S_READ);
        cmd.load_out   = load_out;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = (status.is_read == OP_READ) ? S_CALC : S_IDLE;
            end
            S_CALC:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// File: design/frfe_datapath.sv
// Datapath of the frame rotate/flip engine: position counters, address unit and frame store.
// Depends on frfe_pkg; sequenced by the command struct from frfe_ctrl.
module frfe_datapath #(
    parameter int MAX_WIDTH  = frfe_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = frfe_pkg::MAX_HEIGHT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [frfe_pkg::DIM_W-1:0]   image_width,
    input  logic [frfe_pkg::DIM_W-1:0]   image_height,
    input  logic [frfe_pkg::MODE_W-1:0]  transform_mode,
    input  logic                         opcode,
    input  logic [frfe_pkg::PIXEL_W-1:0] pixel_in,
    input  frfe_pkg::frfe_cmd_t           cmd,
    output frfe_pkg::frfe_status_t        status,
    output logic [frfe_pkg::PIXEL_W-1:0] pixel_out,
    output logic                         end_of_frame
);
    import frfe_pkg::*;

    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int WDW   = $clog2(MAX_WIDTH + 1);
    localparam int HDW   = $clog2(MAX_HEIGHT + 1);
    localparam int ODW   = $clog2(MAXD + 1);
    localparam int CW    = $clog2(MAXD);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int PW    = YW + WDW + 1;

    logic [PIXEL_W-1:0] frame_mem [DEPTH];

    logic               opcode_reg;
    logic [PIXEL_W-1:0] pixel_reg;
    logic [WDW-1:0]     w_reg;
    logic [WDW-1:0]     w_next;
    logic [HDW-1:0]     h_reg;
    logic [HDW-1:0]     h_next;
    logic [TW-1:0]      total_reg;
    logic [TW-1:0]      total_next;
    logic [WDW+HDW-1:0] area;
    logic               swap_reg;
    logic               swap_next;

    logic [AW-1:0]      wpos_reg;
    logic [AW-1:0]      wpos_next;
    logic [AW-1:0]      wpos_eff;
    logic [TW-1:0]      wpos_inc;
    logic [CW-1:0]      row_reg;
    logic [CW-1:0]      row_next;
    logic [CW-1:0]      col_reg;
    logic [CW-1:0]      col_next;

    logic [ODW-1:0]     ow;
    logic [ODW-1:0]     oh;
    logic [ODW-1:0]     r;
    logic [ODW-1:0]     c;
    logic [ODW-1:0]     r_inc;
    logic [ODW-1:0]     c_inc;
    logic [ODW-1:0]     wm1;
    logic [ODW-1:0]     hm1;
    logic [ODW-1:0]     a_wide;
    logic [ODW-1:0]     b_wide;
    logic               last_next;

    logic [YW-1:0]      a_reg;
    logic [XW-1:0]      b_reg;
    logic               last_reg;
    logic [PW-1:0]      addr_sum;
    logic [AW-1:0]      addr_reg;
    logic [PIXEL_W-1:0] rd_data_reg;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic               out_last_reg;

    assign status.is_read = opcode_reg;
    assign pixel_out      = out_pixel_reg;
    assign end_of_frame   = out_last_reg;

    always_comb
    begin
        if (image_width == '0)
        begin
            w_next = WDW'(1);
        end
        else if (32'(image_width) > MAX_WIDTH)
        begin
            w_next = WDW'(MAX_WIDTH);
        end
        else
        begin
            w_next = WDW'(image_width);
        end

        if (image_height == '0)
        begin
            h_next = HDW'(1);
        end
        else if (32'(image_height) > MAX_HEIGHT)
        begin
            h_next = HDW'(MAX_HEIGHT);
        end
        else
        begin
            h_next = HDW'(image_height);
        end

        area       = (WDW+HDW)'(w_next) * (WDW+HDW)'(h_next);
        total_next = area[TW-1:0];
        swap_next  = transform_mode inside {MODE_ROT_CW, MODE_ROT_CCW};
    end

    always_comb
    begin
        wpos_eff  = (TW'(wpos_reg) >= total_reg) ? '0 : wpos_reg;
        wpos_inc  = TW'(wpos_eff) + TW'(1);
        wpos_next = (wpos_inc >= total_reg) ? '0 : wpos_inc[AW-1:0];
    end

    always_comb
    begin
        ow  = swap_reg ? ODW'(h_reg) : ODW'(w_reg);
        oh  = swap_reg ? ODW'(w_reg) : ODW'(h_reg);
        wm1 = ODW'(w_reg) - ODW'(1);
        hm1 = ODW'(h_reg) - ODW'(1);

        if ((ODW'(row_reg) >= oh) || (ODW'(col_reg) >= ow))
        begin
            r = '0;
            c = '0;
        end
        else
        begin
            r = ODW'(row_reg);
            c = ODW'(col_reg);
        end

        case (transform_mode)
            MODE_ROT_CW:
            begin
                a_wide = hm1 - c;
                b_wide = r;
            end
            MODE_ROT_CCW:
            begin
                a_wide = c;
                b_wide = wm1 - r;
            end
            MODE_ROT_180:
            begin
                a_wide = hm1 - r;
                b_wide = wm1 - c;
            end
            MODE_FLIP_V:
            begin
                a_wide = hm1 - r;
                b_wide = c;
            end
            MODE_MIRROR_H:
            begin
                a_wide = r;
                b_wide = wm1 - c;
            end
            default:
            begin
                a_wide = r;
                b_wide = c;
            end
        endcase

        last_next = (r == oh - ODW'(1)) && (c == ow - ODW'(1));
        r_inc     = r + ODW'(1);
        c_inc     = c + ODW'(1);

        if (c_inc >= ow)
        begin
            col_next = '0;
            row_next = (r_inc >= oh) ? '0 : r_inc[CW-1:0];
        end
        else
        begin
            col_next = c_inc[CW-1:0];
            row_next = r[CW-1:0];
        end
    end

    assign addr_sum = PW'(a_reg) * PW'(w_reg) + PW'(b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else
        begin
            if (cmd.exec_write)
            begin
                wpos_reg <= wpos_next;
            end
            if (cmd.exec_read)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        h_reg     <= h_next;
        total_reg <= total_next;
        swap_reg  <= swap_next;
        if (cmd.accept)
        begin
            opcode_reg <= opcode;
            pixel_reg  <= pixel_in;
        end
        if (cmd.exec_read)
        begin
            a_reg    <= a_wide[YW-1:0];
            b_reg    <= b_wide[XW-1:0];
            last_reg <= last_next;
        end
        if (cmd.calc)
        begin
            addr_reg <= addr_sum[AW-1:0];
        end
        if (cmd.load_out)
        begin
            out_pixel_reg <= rd_data_reg;
            out_last_reg  <= last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_write)
        begin
            frame_mem[wpos_eff] <= pixel_reg;
        end
        if (cmd.mem_read)
        begin
            rd_data_reg <= frame_mem[addr_reg];
        end
    end

endmodule
